// ===== hw/rtl/dsm2fs_pkg.sv =====
// Package for the DSM2 frame serializer.
// Holds the frame geometry, header codes, register indexes and shared types.
// No dependencies.
package dsm2fs_pkg;

  localparam int NUM_CHANNELS = 6;
  localparam int IDLE_BITS    = 16;
  localparam int FRAME_BYTES  = 2 + 2 * NUM_CHANNELS;
  localparam int CHAR_W       = 11;
  localparam int TOTAL_BITS   = FRAME_BYTES * CHAR_W + IDLE_BITS;
  localparam int NUM_OUT      = TOTAL_BITS / 8;
  localparam int ACC_W        = 24;
  localparam int ACC_CNT_W    = $clog2(ACC_W + 1);
  localparam int OUT_CNT_W    = $clog2(NUM_OUT + 1);
  localparam int CHAR_IDX_W   = $clog2(FRAME_BYTES + 1);
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CHAN_W       = 12;
  localparam int PULSE_W      = 10;
  localparam int PROD_W       = CHAN_W + 5;
  localparam int CFG_IDX_W    = 8;

  localparam logic [7:0] HDR_RESET        = 8'hFF;
  localparam logic [7:0] HDR_INVALID_MASK = 8'h47;
  localparam logic [7:0] HDR_LP45         = 8'h80;
  localparam logic [7:0] HDR_DSM2         = 8'h90;
  localparam logic [7:0] HDR_DSMX         = 8'h98;
  localparam int         HDR_BIND_BIT     = 7;
  localparam int         HDR_RANGE_BIT    = 5;

  localparam logic [1:0] MODE_LP45  = 2'd0;
  localparam logic [1:0] MODE_DSM2  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODEL_ID      = 8'd1;

  localparam logic signed [CHAN_W-1:0] PULSE_CENTER = 12'sd512;
  localparam logic signed [CHAN_W-1:0] PULSE_MAX    = 12'sd1023;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef logic [NUM_CHANNELS-1:0][CHAN_W-1:0] chan_vec_t;

  typedef struct packed {
    logic              start;
    logic              app_valid;
    logic [CHAR_W-1:0] char_bits;
  } pack_ctrl_t;

  typedef struct packed {
    logic app_ready;
    logic done;
  } pack_stat_t;

endpackage

// ===== hw/rtl/dsm2_frame_serializer.sv =====
// Top level of the DSM2 frame serializer: sequencer, header state, registers.
// Instantiates dsm2fs_byte_unit and dsm2fs_packer. Depends on dsm2fs_pkg.
//
// Each accepted frame request yields 21 output bytes: a 14-byte radio-control
// frame sent as 11-bit serial characters (start 0, eight data bits LSB first,
// two stop 1s) followed by 14 idle 1s, packed LSB first; last_o marks the final
// byte. Up to one character per cycle is built by a shared byte unit and
// appended to a 24-bit packer when it has room; the packer emits at most one
// byte per cycle. A frame request is taken only in idle; then the first
// character is loaded, the 21 bytes are emitted one per cycle while the output
// side does not stall, and the sequencer returns to idle; no new frame is
// accepted before that. in_ready_o stays low from acceptance until the cycle
// after the last byte has been handed to the output register. The header byte
// is loaded from protocol_mode at the first frame after reset; later frames only
// update its bind bit (cleared once bind_switch_i is low) and its range bit.
module dsm2_frame_serializer import dsm2fs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CHAN_W-1:0]    chan0_i,
  input  logic [CHAN_W-1:0]    chan1_i,
  input  logic [CHAN_W-1:0]    chan2_i,
  input  logic [CHAN_W-1:0]    chan3_i,
  input  logic [CHAN_W-1:0]    chan4_i,
  input  logic [CHAN_W-1:0]    chan5_i,
  input  logic                 bind_switch_i,
  input  logic                 range_check_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           stream_byte_o,
  output logic                 last_o
);

  state_e                state_q, state_d;
  logic [1:0]            mode_q, mode_d;
  logic [7:0]            model_id_q, model_id_d;
  logic [7:0]            header_q, header_d, hdr_load;
  logic [CHAR_IDX_W-1:0] char_idx_q, char_idx_d;
  chan_vec_t             chans_q, chans_d;
  logic                  in_acc, cfg_acc;
  logic [7:0]            frame_byte;
  pack_ctrl_t            pack_ctrl;
  pack_stat_t            pack_stat;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    mode_d     = mode_q;
    model_id_d = model_id_q;
    if (cfg_acc) begin
      unique case (cfg_index_i)
        REG_PROTOCOL_MODE: mode_d     = cfg_data_i[1:0];
        REG_MODEL_ID:      model_id_d = cfg_data_i;
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (mode_q)
      MODE_LP45: hdr_load = HDR_LP45;
      MODE_DSM2: hdr_load = HDR_DSM2;
      default:   hdr_load = HDR_DSMX;
    endcase
    header_d = header_q;
    if (in_acc) begin
      if ((header_q & HDR_INVALID_MASK) != 8'h00) begin
        header_d = hdr_load;
      end
      if (header_d[HDR_BIND_BIT] && !bind_switch_i) begin
        header_d[HDR_BIND_BIT] = 1'b0;
      end
      header_d[HDR_RANGE_BIT] = !header_d[HDR_BIND_BIT] && range_check_i;
    end
  end

  always_comb begin
    chans_d = chans_q;
    if (in_acc) begin
      chans_d = {chan5_i, chan4_i, chan3_i, chan2_i, chan1_i, chan0_i};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RUN;
      ST_RUN:  if (pack_stat.done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o          = 1'b0;
    pack_ctrl.start     = 1'b0;
    pack_ctrl.app_valid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        pack_ctrl.start = in_valid_i;
      end
      ST_RUN: begin
        pack_ctrl.app_valid = 1'b1;
      end
      default: ;
    endcase
    if (char_idx_q < CHAR_IDX_W'(FRAME_BYTES)) begin
      pack_ctrl.char_bits = {2'b11, frame_byte, 1'b0};
    end else begin
      pack_ctrl.char_bits = '1;
    end
  end

  always_comb begin
    char_idx_d = char_idx_q;
    if (in_acc) begin
      char_idx_d = '0;
    end else if (pack_stat.app_ready && char_idx_q < CHAR_IDX_W'(FRAME_BYTES)) begin
      char_idx_d = char_idx_q + CHAR_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MODE_RESET;
      model_id_q <= '0;
      header_q   <= HDR_RESET;
      char_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      model_id_q <= model_id_d;
      header_q   <= header_d;
      char_idx_q <= char_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chans_q <= chans_d;
  end

  dsm2fs_byte_unit u_byte_unit (
    .char_idx_i (char_idx_q),
    .header_i   (header_q),
    .model_id_i (model_id_q),
    .chans_i    (chans_q),
    .byte_o     (frame_byte)
  );

  dsm2fs_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (pack_ctrl),
    .stat_o        (pack_stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .stream_byte_o (stream_byte_o),
    .last_o        (last_o)
  );

endmodule

// ===== hw/rtl/dsm2fs_byte_unit.sv =====
// Shared byte unit: selects header, model id or a scaled channel byte.
// Scales the selected channel to a 10-bit pulse. Depends on dsm2fs_pkg.
module dsm2fs_byte_unit import dsm2fs_pkg::*; (
  input  logic [CHAR_IDX_W-1:0] char_idx_i,
  input  logic [7:0]            header_i,
  input  logic [7:0]            model_id_i,
  input  chan_vec_t             chans_i,
  output logic [7:0]            byte_o
);

  logic [CHAR_IDX_W-1:0]    rel;
  logic [CH_IDX_W-1:0]      ch_idx;
  logic signed [CHAN_W-1:0] sel;
  logic signed [PROD_W-1:0] ext;
  logic signed [PROD_W-1:0] prod;
  logic signed [CHAN_W-1:0] sum;
  logic [PULSE_W-1:0]       pulse;

  assign rel    = char_idx_i - CHAR_IDX_W'(2);
  assign ch_idx = rel[CH_IDX_W:1];
  assign sel    = (32'(ch_idx) < NUM_CHANNELS) ? $signed(chans_i[ch_idx]) : '0;
  assign ext    = PROD_W'(sel);
  assign prod   = (ext <<< 3) + (ext <<< 2) + ext;
  assign sum    = $signed(prod[PROD_W-1:5]) + PULSE_CENTER;

  always_comb begin
    if (sum < 0) begin
      pulse = '0;
    end else if (sum > PULSE_MAX) begin
      pulse = PULSE_MAX[PULSE_W-1:0];
    end else begin
      pulse = sum[PULSE_W-1:0];
    end
  end

  always_comb begin
    if (char_idx_i == CHAR_IDX_W'(0)) begin
      byte_o = header_i;
    end else if (char_idx_i == CHAR_IDX_W'(1)) begin
      byte_o = model_id_i;
    end else if (!char_idx_i[0]) begin
      byte_o = 8'({ch_idx, 2'b00}) | {6'b0, pulse[9:8]};
    end else begin
      byte_o = pulse[7:0];
    end
  end

endmodule

// ===== hw/rtl/dsm2fs_packer.sv =====
// Bit packer: appends 11-bit serial characters and emits bytes of the stream.
// Owns the output register and the emitted-byte count. Depends on dsm2fs_pkg.
module dsm2fs_packer import dsm2fs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pack_ctrl_t ctrl_i,
  output pack_stat_t stat_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] stream_byte_o,
  output logic       last_o
);

  logic [ACC_W-1:0]     acc_q, acc_d, acc_after;
  logic [ACC_CNT_W-1:0] cnt_q, cnt_d, cnt_after;
  logic [OUT_CNT_W-1:0] nbyte_q, nbyte_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 out_last_q, out_last_d;
  logic                 out_free, emit, space, append;

  assign out_free  = !out_valid_q || out_ready_i;
  assign emit      = !ctrl_i.start && (cnt_q >= ACC_CNT_W'(8)) && out_free
                     && (nbyte_q != OUT_CNT_W'(NUM_OUT));
  assign cnt_after = emit ? cnt_q - ACC_CNT_W'(8) : cnt_q;
  assign acc_after = emit ? acc_q >> 8 : acc_q;
  assign space     = cnt_after <= ACC_CNT_W'(ACC_W - CHAR_W);
  assign append    = ctrl_i.app_valid && space;

  always_comb begin
    if (ctrl_i.start) begin
      acc_d   = '0;
      cnt_d   = '0;
      nbyte_d = '0;
    end else begin
      acc_d   = append ? acc_after | (ACC_W'(ctrl_i.char_bits) << cnt_after) : acc_after;
      cnt_d   = append ? cnt_after + ACC_CNT_W'(CHAR_W) : cnt_after;
      nbyte_d = emit ? nbyte_q + OUT_CNT_W'(1) : nbyte_q;
    end
    out_valid_d = emit || (out_valid_q && !out_ready_i);
    out_byte_d  = emit ? acc_q[7:0] : out_byte_q;
    out_last_d  = emit ? (nbyte_q == OUT_CNT_W'(NUM_OUT - 1)) : out_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      nbyte_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      nbyte_q     <= nbyte_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign stat_o.app_ready = append;
  assign stat_o.done      = (nbyte_q == OUT_CNT_W'(NUM_OUT));
  assign out_valid_o      = out_valid_q;
  assign stream_byte_o    = out_byte_q;
  assign last_o           = out_last_q;

endmodule

// ===== hw/rtl/dsm2fs_checker.sv =====
// Port-level checker for the DSM2 frame serializer, bound to the top level.
// Counts output transactions per frame. Depends on dsm2fs_pkg.
module dsm2fs_checker import dsm2fs_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] stream_byte_o,
  input logic       last_o
);

  logic [OUT_CNT_W-1:0] seen_q, seen_d;
  logic                 out_acc;

  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    seen_d = seen_q;
    if (out_acc) begin
      seen_d = last_o ? '0 : seen_q + OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a frame transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(stream_byte_o) && $stable(last_o))
    else $error("stalled output transaction changed");

  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_o |-> seen_q == OUT_CNT_W'(NUM_OUT - 1))
    else $error("last byte at wrong position");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_o |-> seen_q < OUT_CNT_W'(NUM_OUT - 1))
    else $error("frame longer than expected");

  a_start_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q == '0 |-> !stream_byte_o[0])
    else $error("first byte lacks start bit");

endmodule

bind dsm2_frame_serializer dsm2fs_checker u_dsm2fs_checker (.*);
